@@ src/iid_pkg.sv @@
// Shared types and constants for the image integrate/differentiate block.
// No dependencies; imported by every module of the block.
package iid_pkg;

   // Default and limit of the line store depth
   localparam int IID_MAX_WIDTH = 4096;

   // Configuration register file
   localparam int IID_CSR_DATA_W = 13;
   localparam int IID_CSR_INDEX_W = 1;
   localparam logic [IID_CSR_INDEX_W-1:0] IID_REG_MODE = 1'd0;
   localparam logic [IID_CSR_INDEX_W-1:0] IID_REG_IMAGE_WIDTH = 1'd1;
   localparam logic [IID_CSR_DATA_W-1:0] IID_IMAGE_WIDTH_RESET = 13'd4096;

   // Mode encoding
   localparam logic IID_MODE_INTEGRATE = 1'b0;
   localparam logic IID_MODE_DIFFERENTIATE = 1'b1;

   // Pixel geometry: four 8-bit channels, red in the low byte
   localparam int IID_CHAN_W = 8;
   localparam int IID_LANES = 4;
   localparam int IID_PIX_W = IID_CHAN_W * IID_LANES;

   typedef struct packed {
      logic       start_of_frame;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] alpha_in;
   } iid_req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [7:0] alpha_out;
   } iid_rsp_type;

   // Position and mode flags shared by all channel lanes
   typedef struct packed {
      logic mode;
      logic col_zero;
      logic first_row;
   } iid_lane_ctrl_type;

endpackage

@@ src/image_integrate_differentiate.sv @@
// Top level of the streaming 2D prefix sum / inverse second difference block.
// Depends on iid_pkg, iid_line_store and iid_lane.
//
//   Channel | Direction | Handshake              | Payload
//   req     | in        | req_valid / req_ready  | req_data  (iid_req_type)
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_data  (iid_rsp_type)
//   csr     | in        | csr_wr_en              | csr_index, csr_wdata
//
// One pixel per clock sustained while rsp_ready holds; rsp_valid is driven from an output
// register behind the compute stage. The line store read is registered: it is issued
// at acceptance and the four channel lanes use its result in the compute stage.
// A same-entry write from the preceding pixel is forwarded around the store.
// Reset is synchronous; the line store itself is not cleared, the first row
// never uses its contents. When rsp stalls, the compute stage and the output register
// each hold one pixel, and req_ready drops once both are full.
module image_integrate_differentiate
   import iid_pkg::*;
#(
   parameter int MAX_WIDTH = IID_MAX_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  iid_req_type                req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output iid_rsp_type                rsp_data,
   input  logic                       csr_wr_en,
   input  logic [IID_CSR_INDEX_W-1:0] csr_index,
   input  logic [IID_CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = (CW + 1 > IID_CSR_DATA_W) ? CW + 1 : IID_CSR_DATA_W;

   // Configuration registers
   logic                      mode_ff;
   logic [IID_CSR_DATA_W-1:0] image_width_ff;

   // Position state, advanced at acceptance
   logic [CW-1:0] col_ff, col_in;
   logic          first_row_ff, first_row_in;

   // Compute stage
   logic                 b_valid_ff;
   logic [IID_PIX_W-1:0] b_pix_ff;
   logic [CW-1:0]        b_col_ff;
   logic                 b_first_ff;
   logic                 fwd_ff;
   logic [IID_PIX_W-1:0] fwd_data_ff;

   // Neighbour state, advanced when the compute stage retires
   logic [IID_PIX_W-1:0] left_ff;
   logic [IID_PIX_W-1:0] up_left_ff;
   logic [IID_PIX_W-1:0] row_sum_ff;

   // Output register
   logic        rsp_valid_ff;
   iid_rsp_type rsp_data_ff;

   logic                 accept;
   logic                 b_adv;
   logic [CW-1:0]        col_sel;
   logic                 first_sel;
   logic [WW-1:0]        eff_width;
   logic [WW-1:0]        col_plus;
   logic [IID_PIX_W-1:0] req_pix;
   logic [IID_PIX_W-1:0] rd_data;
   logic [IID_PIX_W-1:0] up_raw;
   logic [IID_PIX_W-1:0] up_gated;
   logic [IID_PIX_W-1:0] row_sum_next;
   logic [IID_PIX_W-1:0] result;
   logic [IID_PIX_W-1:0] wr_data;
   iid_lane_ctrl_type    lane_ctrl;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= IID_MODE_INTEGRATE;
         image_width_ff <= IID_IMAGE_WIDTH_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            IID_REG_MODE:        mode_ff        <= csr_wdata[0];
            IID_REG_IMAGE_WIDTH: image_width_ff <= csr_wdata;
            default:             ;
         endcase
      end
   end

   // Handshake: the compute stage retires into a free or draining output register
   assign b_adv     = b_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !b_valid_ff || b_adv;
   assign accept    = req_valid && req_ready;

   assign req_pix = {req_data.alpha_in, req_data.blue_in,
                     req_data.green_in, req_data.red_in};

   // Clamp the row width to the range the line store covers
   always_comb begin
      if (image_width_ff == '0) begin
         eff_width = WW'(1);
      end else if (WW'(image_width_ff) > WW'(MAX_WIDTH)) begin
         eff_width = WW'(MAX_WIDTH);
      end else begin
         eff_width = WW'(image_width_ff);
      end
   end

   // Restart the position on a frame start, then step to the next column
   always_comb begin
      col_sel      = req_data.start_of_frame ? '0 : col_ff;
      first_sel    = req_data.start_of_frame | first_row_ff;
      col_plus     = WW'(col_sel) + WW'(1);
      col_in       = col_ff;
      first_row_in = first_row_ff;
      if (accept) begin
         if (col_plus >= eff_width) begin
            col_in       = '0;
            first_row_in = 1'b0;
         end else begin
            col_in       = col_plus[CW-1:0];
            first_row_in = first_sel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         first_row_ff <= 1'b1;
      end else begin
         col_ff       <= col_in;
         first_row_ff <= first_row_in;
      end
   end

   // Load the compute stage; note a same-entry write from the retiring pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (accept) begin
         b_valid_ff <= 1'b1;
      end else if (b_adv) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_pix_ff    <= req_pix;
         b_col_ff    <= col_sel;
         b_first_ff  <= first_sel;
         fwd_ff      <= b_adv && (b_col_ff == col_sel);
         fwd_data_ff <= wr_data;
      end
   end

   iid_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_store (
      .clock      (clock),
      .wr_en      (b_adv),
      .wr_addr    (b_col_ff),
      .wr_data    (wr_data),
      .rd_en      (accept),
      .rd_addr    (col_sel),
      .rd_data_ff (rd_data)
   );

   assign up_raw = fwd_ff ? fwd_data_ff : rd_data;

   assign lane_ctrl.mode      = mode_ff;
   assign lane_ctrl.col_zero  = (b_col_ff == '0);
   assign lane_ctrl.first_row = b_first_ff;

   // One lane per colour channel
   for (genvar k = 0; k < IID_LANES; k++) begin : g_lane
      iid_lane u_lane (
         .ctrl         (lane_ctrl),
         .pix          (b_pix_ff[k*IID_CHAN_W +: IID_CHAN_W]),
         .up           (up_raw[k*IID_CHAN_W +: IID_CHAN_W]),
         .left         (left_ff[k*IID_CHAN_W +: IID_CHAN_W]),
         .up_left      (up_left_ff[k*IID_CHAN_W +: IID_CHAN_W]),
         .row_sum      (row_sum_ff[k*IID_CHAN_W +: IID_CHAN_W]),
         .up_gated     (up_gated[k*IID_CHAN_W +: IID_CHAN_W]),
         .row_sum_next (row_sum_next[k*IID_CHAN_W +: IID_CHAN_W]),
         .result       (result[k*IID_CHAN_W +: IID_CHAN_W])
      );
   end

   // Merge: results feed the line store in integrate mode, inputs otherwise
   assign wr_data = (mode_ff == IID_MODE_DIFFERENTIATE) ? b_pix_ff : result;

   // Advance the neighbour state as each pixel retires
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= '0;
         up_left_ff <= '0;
         row_sum_ff <= '0;
      end else if (b_adv) begin
         left_ff    <= b_pix_ff;
         up_left_ff <= up_gated;
         row_sum_ff <= row_sum_next;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (b_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         rsp_data_ff.red_out   <= result[0*IID_CHAN_W +: IID_CHAN_W];
         rsp_data_ff.green_out <= result[1*IID_CHAN_W +: IID_CHAN_W];
         rsp_data_ff.blue_out  <= result[2*IID_CHAN_W +: IID_CHAN_W];
         rsp_data_ff.alpha_out <= result[3*IID_CHAN_W +: IID_CHAN_W];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ src/iid_lane.sv @@
// One channel lane: running row sum and integrate/differentiate result.
// Depends on iid_pkg for the lane control struct and channel width.
module iid_lane
   import iid_pkg::*;
(
   input  iid_lane_ctrl_type      ctrl,
   input  logic [IID_CHAN_W-1:0]  pix,
   input  logic [IID_CHAN_W-1:0]  up,
   input  logic [IID_CHAN_W-1:0]  left,
   input  logic [IID_CHAN_W-1:0]  up_left,
   input  logic [IID_CHAN_W-1:0]  row_sum,
   output logic [IID_CHAN_W-1:0]  up_gated,
   output logic [IID_CHAN_W-1:0]  row_sum_next,
   output logic [IID_CHAN_W-1:0]  result
);

   logic [IID_CHAN_W-1:0] left_gated;
   logic [IID_CHAN_W-1:0] up_left_gated;
   logic [IID_CHAN_W-1:0] row_sum_gated;

   // Zero the neighbours that fall outside the image
   assign up_gated      = ctrl.first_row ? '0 : up;
   assign left_gated    = ctrl.col_zero ? '0 : left;
   assign up_left_gated = (ctrl.col_zero || ctrl.first_row) ? '0 : up_left;
   assign row_sum_gated = ctrl.col_zero ? '0 : row_sum;

   // Accumulate this row's inputs, wrapping at the channel width
   assign row_sum_next = row_sum_gated + pix;

   // Select the integrate or differentiate result
   always_comb begin
      if (ctrl.mode == IID_MODE_DIFFERENTIATE) begin
         result = pix - up_gated - left_gated + up_left_gated;
      end else begin
         result = up_gated + row_sum_next;
      end
   end

endmodule

@@ src/iid_line_store.sv @@
// Previous-row line store: one write port, one registered read port.
// Depends on iid_pkg for the pixel width.
module iid_line_store
   import iid_pkg::*;
#(
   parameter int DEPTH = IID_MAX_WIDTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [IID_PIX_W-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [IID_PIX_W-1:0] rd_data_ff
);

   logic [IID_PIX_W-1:0] mem [DEPTH];

   // Read returns the old contents when both ports hit one entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

endmodule
